FILE: hdl/bmpdec_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helper functions for the BMP stream pixel decoder.
// No dependencies; the top level and the header check unit import this package.
`default_nettype none

package bmpdec_pkg;

   // Palette storage depth and its address width.
   localparam int PALETTE_DEPTH = 256;
   localparam int PAL_AW        = $clog2(PALETTE_DEPTH);

   // Result kinds.
   localparam logic KIND_PIXEL  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef enum logic [2:0] {
      STAT_OK          = 3'd0,
      STAT_TOO_SMALL   = 3'd1,
      STAT_BAD_SIG     = 3'd2,
      STAT_INVALID     = 3'd3,
      STAT_UNSUPPORTED = 3'd4,
      STAT_CORRUPT     = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_DATA,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      TOP_RUN,
      TOP_CHECK,
      TOP_LOOK
   } top_state_type;

   typedef enum logic [1:0] {
      CK_IDLE,
      CK_EVAL,
      CK_MUL,
      CK_FINAL
   } chk_state_type;

   // One input transaction.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_req;
   } req_payload_type;

   // One result transaction.
   typedef struct packed {
      logic        kind;
      logic [30:0] col;
      logic [30:0] row;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [2:0]  status;
      logic        final_res;
   } rsp_payload_type;

   // Captured header fields.
   typedef struct packed {
      logic [15:0] sig;
      logic [31:0] fsize;
      logic [31:0] off;
      logic [31:0] hs;
      logic [31:0] width;
      logic [31:0] height;
      logic [15:0] planes;
      logic [15:0] bpp;
      logic [31:0] cmp;
      logic [31:0] colors;
   } hdr_type;

   // Result of the header check unit.
   typedef struct packed {
      logic        done;
      logic [2:0]  status;
      logic [33:0] row_bytes;
      logic [32:0] wbytes;
      logic [31:0] hmag;
   } chk_res_type;

   // Replaces byte k of a 32-bit word.
   function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] k,
                                            input logic [7:0] b);
      logic [31:0] r;
      r = w;
      r[{k, 3'b000} +: 8] = b;
      return r;
   endfunction

   // Trailing zero count of a nonzero byte.
   function automatic logic [2:0] tz8(input logic [7:0] b);
      logic [2:0] n;
      n = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (b[i]) begin
            n = 3'(i);
         end
      end
      return n;
   endfunction

   // Bitfield channel extraction with a precomputed shift.
   function automatic logic [7:0] chan(input logic [31:0] v, input logic [31:0] m,
                                       input logic [4:0] tz);
      logic [31:0] t;
      t = (v & m) >> tz;
      if (m == 32'd0) begin
         return 8'd0;
      end
      return t[7:0];
   endfunction

endpackage

`default_nettype wire

FILE: hdl/bmp_stream_pixel_decoder.sv
`timescale 1ns / 1ps
// BMP stream pixel decoder, top level. Depends on bmpdec_pkg, bmpdec_ram
// and bmpdec_hdr_check.
//
// Usage: the file arrives one byte per req_ transaction, in file order;
// start_req marks the first byte of a new file. file_size is written over
// the csr_ channel while the block is idle. Each pixel gives one rsp_
// transaction with its destination coordinates and ARGB value; a failed
// header check gives one status transaction, after which the rest of the
// file is ignored until the next start_req.
// Throughput: one byte per cycle for header, table, padding and 24/32-bit
// pixel bytes while no result is stalled. An 8-bit palette pixel holds off
// the next byte until the registered read of the palette RAM is done. After
// the byte at offset 53 no byte is taken while the header check runs its
// 32-step shift-add multiplier that forms row size times height.
// A non-palette result enters the output register in the cycle after its
// last byte; a palette pixel passes the palette RAM read and TOP_LOOK first.
// Reset clears the parse state and file_size; the palette RAM is not
// cleared. While the receiver stalls a waiting result, no further byte is
// taken unless the result register drains in the same cycle.
`default_nettype none

module bmp_stream_pixel_decoder
   import bmpdec_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire req_payload_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output rsp_payload_type      rsp_payload,
   input  wire logic            csr_valid,
   output logic                 csr_ready,
   input  wire logic [31:0]     csr_data
);

   top_state_type    state_ff, state_in;
   phase_type        phase_ff, phase_in;
   logic [31:0]      pos_ff, pos_in;
   hdr_type          hdr_ff, hdr_in;
   logic [3:0][31:0] mask_ff, mask_in;
   logic [3:0][4:0]  tz_ff, tz_in;
   logic [23:0]      asm_ff, asm_in;
   logic [1:0]       kcnt_ff, kcnt_in;
   logic [30:0]      col_ff, col_in;
   logic [30:0]      row_ff, row_in;
   logic [31:0]      rbc_ff, rbc_in;
   logic [15:0]      hold_ff, hold_in;
   logic [31:0]      fsize_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_pay_ff, rsp_pay_in;
   rsp_payload_type  pend_ff, pend_in;
   logic             pend_ok_ff, pend_ok_in;

   logic              accept;
   logic              chk_start;
   chk_res_type       chk;
   logic              ram_we;
   logic [PAL_AW-1:0] ram_waddr;
   logic [23:0]       ram_wdata;
   logic [PAL_AW-1:0] ram_raddr;
   logic [23:0]       ram_rdata;

   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_pay_ff;
   assign req_stall   = (state_ff != TOP_RUN) || (rsp_valid_ff && rsp_stall);
   assign accept      = req_valid && !req_stall;

   bmpdec_ram #(
      .WIDTH (24),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   bmpdec_hdr_check u_check (
      .clock     (clock),
      .reset     (reset),
      .start     (chk_start),
      .hdr       (hdr_ff),
      .file_size (fsize_ff),
      .res       (chk)
   );

   // Control and parse state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= TOP_RUN;
         phase_ff     <= PH_HEADER;
         pos_ff       <= 32'd0;
         hdr_ff       <= '0;
         mask_ff      <= '0;
         tz_ff        <= '0;
         asm_ff       <= 24'd0;
         kcnt_ff      <= 2'd0;
         col_ff       <= 31'd0;
         row_ff       <= 31'd0;
         rbc_ff       <= 32'd0;
         fsize_ff     <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         hdr_ff       <= hdr_in;
         mask_ff      <= mask_in;
         tz_ff        <= tz_in;
         asm_ff       <= asm_in;
         kcnt_ff      <= kcnt_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rbc_ff       <= rbc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            fsize_ff <= csr_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      hold_ff    <= hold_in;
      rsp_pay_ff <= rsp_pay_in;
      pend_ff    <= pend_in;
      pend_ok_ff <= pend_ok_in;
   end

   // Byte parser, pixel conversion and result formation.
   always_comb begin
      logic [7:0]  b;
      logic [31:0] p;
      logic [5:0]  p6;
      logic [31:0] q;
      logic [31:0] d;
      logic [31:0] base;
      logic [2:0]  bpb;
      logic [31:0] v;
      logic [31:0] pal;
      logic [31:0] am;
      logic [7:0]  r, g, bl, a;
      logic        fin;
      logic [31:0] rbc_nx;
      rsp_payload_type pay;

      state_in     = state_ff;
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      hdr_in       = hdr_ff;
      mask_in      = mask_ff;
      tz_in        = tz_ff;
      asm_in       = asm_ff;
      kcnt_in      = kcnt_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      rbc_in       = rbc_ff;
      hold_in      = hold_ff;
      pend_in      = pend_ff;
      pend_ok_in   = pend_ok_ff;
      rsp_pay_in   = rsp_pay_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      chk_start    = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = '0;
      ram_wdata    = {8'd0, hold_ff};
      ram_raddr    = '0;

      b      = req_payload.data_byte;
      p      = pos_ff;
      p6     = pos_ff[5:0];
      q      = pos_ff - 32'd54;
      base   = 32'd14 + hdr_ff.hs;
      d      = pos_ff - base;
      bpb    = hdr_ff.bpp[5:3];
      pal    = (hdr_ff.colors == 32'd0) ? 32'd256 : hdr_ff.colors;
      am     = (hdr_ff.hs >= 32'd108) ? mask_ff[3] : 32'd0;
      v      = 32'd0;
      r      = 8'd0;
      g      = 8'd0;
      bl     = 8'd0;
      a      = 8'hFF;
      fin    = 1'b0;
      rbc_nx = rbc_ff + 32'd1;
      pay    = '0;

      unique case (state_ff)
         TOP_RUN: begin
            if (accept) begin
               if (req_payload.start_req) begin
                  // Restart the parse with this byte at offset zero.
                  p        = 32'd0;
                  p6       = 6'd0;
                  phase_in = PH_HEADER;
                  hdr_in   = '0;
                  mask_in  = '0;
                  tz_in    = '0;
                  asm_in   = 24'd0;
                  kcnt_in  = 2'd0;
                  col_in   = 31'd0;
                  row_in   = 31'd0;
                  rbc_in   = 32'd0;
               end
               if (req_payload.start_req || phase_ff == PH_HEADER) begin
                  // Header capture, little-endian.
                  pos_in = p + 32'd1;
                  priority if (p6 < 6'd2) begin
                     hdr_in.sig[{p6[0], 3'b000} +: 8] = b;
                  end else if (p6 < 6'd6) begin
                     hdr_in.fsize = put_byte(hdr_in.fsize, 2'(p6 - 6'd2), b);
                  end else if (p6 < 6'd10) begin
                     hdr_in.off = hdr_in.off;
                  end else if (p6 < 6'd14) begin
                     hdr_in.off = put_byte(hdr_in.off, 2'(p6 - 6'd10), b);
                  end else if (p6 < 6'd18) begin
                     hdr_in.hs = put_byte(hdr_in.hs, 2'(p6 - 6'd14), b);
                  end else if (p6 < 6'd22) begin
                     hdr_in.width = put_byte(hdr_in.width, 2'(p6 - 6'd18), b);
                  end else if (p6 < 6'd26) begin
                     hdr_in.height = put_byte(hdr_in.height, 2'(p6 - 6'd22), b);
                  end else if (p6 < 6'd28) begin
                     hdr_in.planes[{p6[0], 3'b000} +: 8] = b;
                  end else if (p6 < 6'd30) begin
                     hdr_in.bpp[{p6[0], 3'b000} +: 8] = b;
                  end else if (p6 < 6'd34) begin
                     hdr_in.cmp = put_byte(hdr_in.cmp, 2'(p6 - 6'd30), b);
                  end else if (p6 >= 6'd46 && p6 < 6'd50) begin
                     hdr_in.colors = put_byte(hdr_in.colors, 2'(p6 - 6'd46), b);
                  end else begin
                     hdr_in.sig = hdr_in.sig;
                  end
                  if (p6 == 6'd53) begin
                     chk_start = 1'b1;
                     state_in  = TOP_CHECK;
                  end
               end else if (phase_ff == PH_DATA) begin
                  pos_in = p + 32'd1;
                  if (p < hdr_ff.off) begin
                     // Bitfield masks.
                     if (p >= 32'd54 && p < 32'd70) begin
                        mask_in[q[3:2]] = put_byte(mask_ff[q[3:2]], q[1:0], b);
                        if (mask_ff[q[3:2]] == 32'd0 && b != 8'd0) begin
                           tz_in[q[3:2]] = {q[1:0], 3'b000} + {2'b00, tz8(b)};
                        end
                     end
                     // Palette entries, assembled and written whole.
                     if (hdr_ff.bpp == 16'd8 && p >= base &&
                         d < 32'(4 * PALETTE_DEPTH)) begin
                        unique case (d[1:0])
                           2'd0: hold_in[7:0] = b;
                           2'd1: hold_in[15:8] = b;
                           2'd2: begin
                              ram_we    = 1'b1;
                              ram_waddr = d[PAL_AW+1:2];
                              ram_wdata = {b, hold_ff};
                           end
                           default: hold_in = hold_ff;
                        endcase
                     end
                  end else begin
                     // Pixel bytes and row padding.
                     if ({1'b0, rbc_ff} < chk.wbytes) begin
                        if ({1'b0, kcnt_ff} + 3'd1 < bpb) begin
                           if (kcnt_ff != 2'd3) begin
                              asm_in[{kcnt_ff, 3'b000} +: 8] = b;
                           end
                           kcnt_in = kcnt_ff + 2'd1;
                        end else begin
                           priority if (bpb == 3'd4) begin
                              v = {b, asm_ff};
                           end else if (bpb == 3'd3) begin
                              v = {8'd0, b, asm_ff[15:0]};
                           end else begin
                              v = {24'd0, b};
                           end
                           bl = v[7:0];
                           g  = v[15:8];
                           r  = v[23:16];
                           if (bpb == 3'd4) begin
                              a = v[31:24];
                              if (hdr_ff.cmp == 32'd3 &&
                                  (mask_ff[0] | mask_ff[1] | mask_ff[2] | am) != 32'd0) begin
                                 r  = chan(v, mask_ff[0], tz_ff[0]);
                                 g  = chan(v, mask_ff[1], tz_ff[1]);
                                 bl = chan(v, mask_ff[2], tz_ff[2]);
                                 a  = (am != 32'd0) ? chan(v, am, tz_ff[3]) : 8'hFF;
                              end
                           end
                           fin = ({1'b0, col_ff} + 32'd1 == hdr_ff.width) &&
                                 ({1'b0, row_ff} + 32'd1 == chk.hmag);
                           pay.kind      = KIND_PIXEL;
                           pay.col       = col_ff;
                           pay.row       = hdr_ff.height[31] ? row_ff :
                                           31'(chk.hmag - 32'd1 - {1'b0, row_ff});
                           pay.red       = r;
                           pay.green     = g;
                           pay.blue      = bl;
                           pay.alpha     = a;
                           pay.status    = STAT_OK;
                           pay.final_res = fin;
                           if (bpb == 3'd1) begin
                              // Palette pixel: result waits for the RAM read.
                              ram_raddr  = b[PAL_AW-1:0];
                              pend_in    = pay;
                              pend_ok_in = ({24'd0, b} < pal) &&
                                           ({1'b0, b} < 9'(PALETTE_DEPTH));
                              state_in   = TOP_LOOK;
                           end else begin
                              rsp_pay_in   = pay;
                              rsp_valid_in = 1'b1;
                           end
                           asm_in  = 24'd0;
                           kcnt_in = 2'd0;
                           col_in  = col_ff + 31'd1;
                        end
                     end
                     if (fin) begin
                        phase_in = PH_DONE;
                     end else begin
                        rbc_in = rbc_nx;
                        if ({2'b00, rbc_nx} >= chk.row_bytes) begin
                           rbc_in  = 32'd0;
                           col_in  = 31'd0;
                           kcnt_in = 2'd0;
                           row_in  = row_ff + 31'd1;
                        end
                     end
                  end
               end
            end
         end
         TOP_CHECK: begin
            if (chk.done) begin
               state_in = TOP_RUN;
               if (chk.status != STAT_OK) begin
                  pay.kind      = KIND_STATUS;
                  pay.status    = chk.status;
                  pay.final_res = 1'b1;
                  rsp_pay_in    = pay;
                  rsp_valid_in  = 1'b1;
                  phase_in      = PH_DONE;
               end else begin
                  phase_in = PH_DATA;
               end
            end
         end
         TOP_LOOK: begin
            // Palette data is now available.
            pay = pend_ff;
            if (pend_ok_ff) begin
               pay.blue  = ram_rdata[7:0];
               pay.green = ram_rdata[15:8];
               pay.red   = ram_rdata[23:16];
               pay.alpha = 8'hFF;
            end else begin
               pay.blue  = 8'd0;
               pay.green = 8'd0;
               pay.red   = 8'd0;
               pay.alpha = 8'd0;
            end
            rsp_pay_in   = pay;
            rsp_valid_in = 1'b1;
            state_in     = TOP_RUN;
         end
         default: begin
            state_in = TOP_RUN;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: hdl/bmpdec_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
`default_nettype none

module bmpdec_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

FILE: hdl/bmpdec_hdr_check.sv
`timescale 1ns / 1ps
// Header check unit: ordered validity checks and the row size times height
// product, computed with a shift-add multiplier. Depends on bmpdec_pkg.
`default_nettype none

module bmpdec_hdr_check
   import bmpdec_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire hdr_type     hdr,
   input  wire logic [31:0] file_size,
   output chk_res_type      res
);

   chk_state_type state_ff, state_in;
   logic          done_ff, done_in;
   logic [2:0]    status_ff, status_in;
   logic [33:0]   rb_ff, rb_in;
   logic [32:0]   wb_ff, wb_in;
   logic [31:0]   hmag_ff, hmag_in;
   logic [65:0]   mcand_ff, mcand_in;
   logic [31:0]   mplier_ff, mplier_in;
   logic [65:0]   acc_ff, acc_in;
   logic [4:0]    cnt_ff, cnt_in;

   assign res.done      = done_ff;
   assign res.status    = status_ff;
   assign res.row_bytes = rb_ff;
   assign res.wbytes    = wb_ff;
   assign res.hmag      = hmag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CK_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      status_ff <= status_in;
      rb_ff     <= rb_in;
      wb_ff     <= wb_in;
      hmag_ff   <= hmag_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
      cnt_ff    <= cnt_in;
   end

   // Check sequence: early checks, multiply, then the data and palette fit.
   always_comb begin
      logic [2:0]  st;
      logic [15:0] bpp;
      logic [32:0] w33;
      logic [32:0] wb;
      logic [33:0] rb;
      logic [31:0] pal;
      logic [34:0] need;
      logic [31:0] room;

      state_in  = state_ff;
      done_in   = 1'b0;
      status_in = status_ff;
      rb_in     = rb_ff;
      wb_in     = wb_ff;
      hmag_in   = hmag_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;

      bpp  = hdr.bpp;
      w33  = {1'b0, hdr.width};
      wb   = 33'd0;
      rb   = 34'd0;
      st   = STAT_OK;
      pal  = (hdr.colors == 32'd0) ? 32'd256 : hdr.colors;
      need = 35'd14 + {3'b000, hdr.hs};
      room = file_size - hdr.off;

      unique case (state_ff)
         CK_IDLE: begin
            if (start) begin
               state_in = CK_EVAL;
            end
         end
         CK_EVAL: begin
            priority if (file_size < 32'd54) begin
               st = STAT_TOO_SMALL;
            end else if (hdr.sig != 16'h4D42) begin
               st = STAT_BAD_SIG;
            end else if (hdr.fsize > file_size) begin
               st = STAT_INVALID;
            end else if (hdr.hs != 32'd40 && hdr.hs != 32'd108 && hdr.hs != 32'd124) begin
               st = STAT_UNSUPPORTED;
            end else if (hdr.width[31] || hdr.width == 32'd0 || hdr.height == 32'd0) begin
               st = STAT_INVALID;
            end else if (bpp != 16'd8 && bpp != 16'd24 && bpp != 16'd32) begin
               st = STAT_UNSUPPORTED;
            end else if (hdr.cmp != 32'd0 && hdr.cmp != 32'd3) begin
               st = STAT_UNSUPPORTED;
            end else if (hdr.planes != 16'd1) begin
               st = STAT_INVALID;
            end else begin
               st = STAT_OK;
            end
            // Row bytes from width and bytes per pixel, padded to four bytes.
            priority if (bpp == 16'd8) begin
               wb = w33;
            end else if (bpp == 16'd24) begin
               wb = w33 + {w33[31:0], 1'b0};
            end else begin
               wb = {w33[30:0], 2'b00};
            end
            rb = ({1'b0, wb} + 34'd3) & ~34'd3;
            wb_in     = wb;
            rb_in     = rb;
            hmag_in   = hdr.height[31] ? (~hdr.height + 32'd1) : hdr.height;
            mcand_in  = {32'd0, rb};
            mplier_in = hdr.height[31] ? (~hdr.height + 32'd1) : hdr.height;
            acc_in    = 66'd0;
            cnt_in    = 5'd0;
            if (st != STAT_OK) begin
               status_in = st;
               done_in   = 1'b1;
               state_in  = CK_IDLE;
            end else begin
               state_in = CK_MUL;
            end
         end
         CK_MUL: begin
            // One multiplier bit per cycle.
            if (mplier_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in  = {mcand_ff[64:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[31:1]};
            cnt_in    = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = CK_FINAL;
            end
         end
         CK_FINAL: begin
            if (bpp == 16'd8) begin
               need = need + {1'b0, pal, 2'b00};
            end
            st = STAT_OK;
            priority if (hdr.off > file_size) begin
               st = STAT_CORRUPT;
            end else if (acc_ff > {34'd0, room}) begin
               st = STAT_CORRUPT;
            end else if (bpp == 16'd8 && need > {3'b000, file_size}) begin
               st = STAT_CORRUPT;
            end else begin
               st = STAT_OK;
            end
            if (bpp == 16'd32 && hdr.cmp == 32'd3) begin
               if (hdr.hs >= 32'd108) begin
                  if (need < 35'd70) begin
                     need = 35'd70;
                  end
               end else if (need < 35'd66) begin
                  need = 35'd66;
               end
            end
            if (st == STAT_OK && {3'b000, hdr.off} < need) begin
               st = STAT_CORRUPT;
            end
            status_in = st;
            done_in   = 1'b1;
            state_in  = CK_IDLE;
         end
         default: begin
            state_in = CK_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire
